>>> rtl/core/ocu_pkg.sv
package ocu_pkg;

  localparam int CORDIC_STEPS = 18;
  localparam int CORDIC_FRAC  = 20;
  localparam int STEP_W       = 5;
  localparam int CW           = 34;   // cordic x/y/z working width
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
  localparam int ONE_Q16      = 65536;

  localparam logic [1:0] CFG_RADIUS   = 2'd0;
  localparam logic [1:0] CFG_TARGET_X = 2'd1;
  localparam logic [1:0] CFG_TARGET_Y = 2'd2;
  localparam logic [1:0] CFG_TARGET_Z = 2'd3;

  // shared multiplier operations
  localparam logic [2:0] MUL_HORIZ = 3'd0;
  localparam logic [2:0] MUL_EYE_Y = 3'd1;
  localparam logic [2:0] MUL_EYE_X = 3'd2;
  localparam logic [2:0] MUL_EYE_Z = 3'd3;
  localparam logic [2:0] MUL_UP_X  = 3'd4;
  localparam logic [2:0] MUL_UP_Z  = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_CORDIC_E,
    ST_CORDIC_A,
    ST_MUL_H,
    ST_MUL_Y,
    ST_MUL_X,
    ST_MUL_Z,
    ST_MUL_UX,
    ST_MUL_UZ,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;       // capture steps, update angles
    logic cordic_init_e;
    logic cordic_init_a;
    logic cordic_step;
    logic save_e;
    logic save_a;
    logic [2:0] mul_sel;
    logic mul_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cordic_done;
  } sts_t;

  function automatic logic signed [CW-1:0] atan_deg(input logic [STEP_W-1:0] i);
    case (i)
      5'd0:  atan_deg = 34'sd47185920;
      5'd1:  atan_deg = 34'sd27855475;
      5'd2:  atan_deg = 34'sd14718068;
      5'd3:  atan_deg = 34'sd7471121;
      5'd4:  atan_deg = 34'sd3750058;
      5'd5:  atan_deg = 34'sd1876857;
      5'd6:  atan_deg = 34'sd938658;
      5'd7:  atan_deg = 34'sd469357;
      5'd8:  atan_deg = 34'sd234682;
      5'd9:  atan_deg = 34'sd117342;
      5'd10: atan_deg = 34'sd58671;
      5'd11: atan_deg = 34'sd29335;
      5'd12: atan_deg = 34'sd14668;
      5'd13: atan_deg = 34'sd7334;
      5'd14: atan_deg = 34'sd3667;
      5'd15: atan_deg = 34'sd1833;
      5'd16: atan_deg = 34'sd917;
      5'd17: atan_deg = 34'sd458;
      default: atan_deg = '0;
    endcase
  endfunction

endpackage

>>> rtl/core/ocu_ctrl.sv
module ocu_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  ocu_pkg::sts_t   sts,
  output ocu_pkg::cmd_t   cmd
);

  ocu_pkg::state_t state, state_next;
  logic ovalid, ovalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ocu_pkg::ST_IDLE;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      ovalid <= ovalid_next;
    end
  end

  // output register frees when taken; ST_OUT waits only if still full
  logic out_free;
  assign out_free = !ovalid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      ocu_pkg::ST_IDLE:     if (in_valid) state_next = ocu_pkg::ST_ANGLE;
      ocu_pkg::ST_ANGLE:    state_next = ocu_pkg::ST_CORDIC_E;
      ocu_pkg::ST_CORDIC_E: if (sts.cordic_done) state_next = ocu_pkg::ST_CORDIC_A;
      ocu_pkg::ST_CORDIC_A: if (sts.cordic_done) state_next = ocu_pkg::ST_MUL_H;
      ocu_pkg::ST_MUL_H:    state_next = ocu_pkg::ST_MUL_Y;
      ocu_pkg::ST_MUL_Y:    state_next = ocu_pkg::ST_MUL_X;
      ocu_pkg::ST_MUL_X:    state_next = ocu_pkg::ST_MUL_Z;
      ocu_pkg::ST_MUL_Z:    state_next = ocu_pkg::ST_MUL_UX;
      ocu_pkg::ST_MUL_UX:   state_next = ocu_pkg::ST_MUL_UZ;
      ocu_pkg::ST_MUL_UZ:   state_next = ocu_pkg::ST_OUT;
      ocu_pkg::ST_OUT:      if (out_free) state_next = ocu_pkg::ST_IDLE;
      default:              state_next = ocu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    ovalid_next = ovalid && !out_ready;
    case (state)
      ocu_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ocu_pkg::ST_ANGLE:    cmd.cordic_init_e = 1'b1;
      ocu_pkg::ST_CORDIC_E: begin
        cmd.cordic_step = !sts.cordic_done;
        if (sts.cordic_done) begin
          cmd.save_e = 1'b1;
          cmd.cordic_init_a = 1'b1;
        end
      end
      ocu_pkg::ST_CORDIC_A: begin
        cmd.cordic_step = !sts.cordic_done;
        cmd.save_a = sts.cordic_done;
      end
      ocu_pkg::ST_MUL_H: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = ocu_pkg::MUL_HORIZ;
      end
      ocu_pkg::ST_MUL_Y: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = ocu_pkg::MUL_EYE_Y;
      end
      ocu_pkg::ST_MUL_X: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = ocu_pkg::MUL_EYE_X;
      end
      ocu_pkg::ST_MUL_Z: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = ocu_pkg::MUL_EYE_Z;
      end
      ocu_pkg::ST_MUL_UX: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = ocu_pkg::MUL_UP_X;
      end
      ocu_pkg::ST_MUL_UZ: begin
        cmd.mul_en = 1'b1; cmd.mul_sel = ocu_pkg::MUL_UP_Z;
      end
      ocu_pkg::ST_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          ovalid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = ovalid;

endmodule

>>> rtl/core/ocu_datapath.sv
module ocu_datapath #(
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  ocu_pkg::cmd_t       cmd,
  output ocu_pkg::sts_t       sts,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic signed [14:0]  elevation_step,
  input  logic signed [14:0]  azimuth_step,
  output logic signed [31:0]  eye_x,
  output logic signed [31:0]  eye_y,
  output logic signed [31:0]  eye_z,
  output logic signed [17:0]  up_x,
  output logic signed [17:0]  up_y,
  output logic signed [17:0]  up_z
);
  localparam int AW = 9 + ANGLE_FRAC_BITS + 2;  // holds 360 deg plus step
  localparam logic signed [AW-1:0] QUARTER = AW'(90 << ANGLE_FRAC_BITS);
  localparam logic signed [AW-1:0] HALF    = AW'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [AW-1:0] THREE_Q = AW'(270 << ANGLE_FRAC_BITS);
  localparam logic signed [AW-1:0] FULL    = AW'(360 << ANGLE_FRAC_BITS);
  localparam int CW = ocu_pkg::CW;
  localparam int ZSH = ocu_pkg::CORDIC_FRAC - ANGLE_FRAC_BITS;

  // config registers
  logic [30:0] orbit_radius;
  logic signed [31:0] target_x, target_y, target_z;
  always_ff @(posedge clk) begin
    if (rst) begin
      orbit_radius <= 31'd65536;
      target_x <= '0;
      target_y <= '0;
      target_z <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ocu_pkg::CFG_RADIUS:   orbit_radius <= cfg_data[30:0];
        ocu_pkg::CFG_TARGET_X: target_x <= cfg_data;
        ocu_pkg::CFG_TARGET_Y: target_y <= cfg_data;
        ocu_pkg::CFG_TARGET_Z: target_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // angle state
  logic signed [AW-1:0] elev, azim;
  logic signed [AW-1:0] es, as_c, e_sum, a_sum, e_new, a_new;
  always_comb begin
    es = AW'(elevation_step);
    if (es > QUARTER) es = QUARTER;
    if (es < -QUARTER) es = -QUARTER;
    as_c = AW'(azimuth_step);
    if (as_c > QUARTER) as_c = QUARTER;
    if (as_c < -QUARTER) as_c = -QUARTER;
    e_sum = elev + es;
    e_new = e_sum;
    if (e_sum < 0) e_new = '0;
    if (e_sum > QUARTER) e_new = QUARTER;
    a_sum = azim + as_c;
    a_new = a_sum;
    if (a_sum >= FULL) a_new = a_sum - FULL;
    else if (a_sum <= 0) a_new = a_sum + FULL;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elev <= AW'(30 << ANGLE_FRAC_BITS);
      azim <= '0;
    end else if (cmd.load) begin
      elev <= e_new;
      azim <= a_new;
    end
  end

  // azimuth quadrant split by compares
  logic [1:0] quad;
  logic signed [AW-1:0] az_r;
  always_comb begin
    if (azim >= FULL)         begin quad = 2'd0; az_r = azim - FULL; end
    else if (azim >= THREE_Q) begin quad = 2'd3; az_r = azim - THREE_Q; end
    else if (azim >= HALF)    begin quad = 2'd2; az_r = azim - HALF; end
    else if (azim >= QUARTER) begin quad = 2'd1; az_r = azim - QUARTER; end
    else                      begin quad = 2'd0; az_r = azim; end
  end

  // shared CORDIC, one rotation per cycle; done once all steps are applied
  logic signed [CW-1:0] cx, cy, cz, dx, dy, at;
  logic [ocu_pkg::STEP_W-1:0] cnt;
  assign at = ocu_pkg::atan_deg(cnt);
  assign dx = cy >>> cnt;
  assign dy = cx >>> cnt;
  assign sts.cordic_done = (cnt == ocu_pkg::STEP_W'(ocu_pkg::CORDIC_STEPS));

  always_ff @(posedge clk) begin
    if (cmd.cordic_init_e || cmd.cordic_init_a) begin
      cx  <= ocu_pkg::CORDIC_X0;
      cy  <= '0;
      cz  <= CW'(cmd.cordic_init_e ? elev : az_r) <<< ZSH;
      cnt <= '0;
    end else if (cmd.cordic_step) begin
      if (cz >= 0) begin
        cx <= cx - dx; cy <= cy + dy; cz <= cz - at;
      end else begin
        cx <= cx + dx; cy <= cy - dy; cz <= cz + at;
      end
      cnt <= cnt + 1'b1;
    end
  end

  // round to Q1.16 and clamp 0..1
  function automatic logic signed [17:0] q16(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    t = (v + CW'(8192)) >>> 14;
    if (t < 0) q16 = '0;
    else if (t > CW'(ocu_pkg::ONE_Q16)) q16 = 18'sd65536;
    else q16 = t[17:0];
  endfunction

  logic signed [17:0] se, ce, sa, ca, sq, cq;
  assign sq = q16(cy);
  assign cq = q16(cx);
  always_ff @(posedge clk) begin
    if (cmd.save_e) begin
      se <= sq;
      ce <= cq;
    end
    if (cmd.save_a) begin
      case (quad)
        2'd0: begin sa <= sq;  ca <= cq;  end
        2'd1: begin sa <= cq;  ca <= -sq; end
        2'd2: begin sa <= -sq; ca <= -cq; end
        default: begin sa <= -cq; ca <= sq; end
      endcase
    end
  end

  // one multiply per cycle: 32x18 signed, rounded Q16
  logic signed [31:0] horiz, ma;
  logic signed [17:0] mb;
  logic signed [49:0] prod;
  logic signed [33:0] rnd;
  logic signed [33:0] tsel;
  logic signed [33:0] sum;
  logic signed [31:0] sat;
  always_comb begin
    ma = '0; mb = '0; tsel = '0;
    case (cmd.mul_sel)
      ocu_pkg::MUL_HORIZ: begin ma = {1'b0, orbit_radius}; mb = ce; end
      ocu_pkg::MUL_EYE_Y: begin
        ma = {1'b0, orbit_radius}; mb = se; tsel = 34'(target_y);
      end
      ocu_pkg::MUL_EYE_X: begin ma = horiz; mb = sa; tsel = 34'(target_x); end
      ocu_pkg::MUL_EYE_Z: begin ma = horiz; mb = ca; tsel = 34'(target_z); end
      ocu_pkg::MUL_UP_X:  begin ma = 32'(se); mb = sa; end
      ocu_pkg::MUL_UP_Z:  begin ma = 32'(se); mb = ca; end
      default: ;
    endcase
    prod = 50'(ma) * 50'(mb);
    rnd  = 34'((prod + 50'sd32768) >>> 16);
    sum  = tsel + rnd;
    if (sum > 34'sd2147483647) sat = 32'sh7fffffff;
    else if (sum < -34'sd2147483648) sat = 32'sh80000000;
    else sat = sum[31:0];
  end

  logic signed [31:0] ex, ey, ez;
  logic signed [17:0] ux, uz;
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        ocu_pkg::MUL_HORIZ: horiz <= sat;
        ocu_pkg::MUL_EYE_Y: ey <= sat;
        ocu_pkg::MUL_EYE_X: ex <= sat;
        ocu_pkg::MUL_EYE_Z: ez <= sat;
        ocu_pkg::MUL_UP_X:  ux <= -rnd[17:0];
        ocu_pkg::MUL_UP_Z:  uz <= -rnd[17:0];
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      eye_x <= ex; eye_y <= ey; eye_z <= ez;
      up_x <= ux; up_y <= ce; up_z <= uz;
    end
  end

endmodule

>>> rtl/core/orbit_camera_update_top.sv
// Channel | Direction | Signals
// in      | input     | in_valid, in_ready, elevation_step, azimuth_step
// cfg     | input     | cfg_valid, cfg_ready, cfg_index, cfg_data
// out     | output    | out_valid, out_ready, eye_x/y/z, up_x/y/z
//
// An input beat is taken only in idle, so a new beat waits until the last one
// has gone through two 18-step CORDIC passes on one shared rotator and six
// products through one shared 32x18 multiplier; out_valid then rises.
// Synchronous active-high reset restores radius 1.0, target 0, elevation 30
// degrees, azimuth 0. The result sits in an output register; while it waits,
// one more input beat is taken and computed, then the input stalls until the
// out channel frees the register.
module orbit_camera_update_top #(
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [14:0] elevation_step,
  input  logic signed [14:0] azimuth_step,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] eye_x,
  output logic signed [31:0] eye_y,
  output logic signed [31:0] eye_z,
  output logic signed [17:0] up_x,
  output logic signed [17:0] up_y,
  output logic signed [17:0] up_z
);

  ocu_pkg::cmd_t cmd;
  ocu_pkg::sts_t sts;

  // config always taken
  assign cfg_ready = 1'b1;

  ocu_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .sts(sts), .cmd(cmd)
  );

  ocu_datapath #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .elevation_step(elevation_step), .azimuth_step(azimuth_step),
    .eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
    .up_x(up_x), .up_y(up_y), .up_z(up_z)
  );

endmodule
